// ===== src/clav_pkg.sv =====
// ----------------------------------------------------------------------------
// clav_pkg
// Shared constants and types of the mouse-look camera view block.
// ----------------------------------------------------------------------------
package clav_pkg;

  localparam int SPD            = 128;   // angle steps per degree (power of two)
  localparam int TILT_LIMIT_DEG = 89;

  localparam int TURN     = 360 * SPD;
  localparam int QUARTER  = 90 * SPD;
  localparam int EIGHTH   = 45 * SPD;
  localparam int TILT_MAX = TILT_LIMIT_DEG * SPD;
  localparam int SPD_SH   = $clog2(SPD);

  localparam int HW = $clog2(TURN);          // heading width
  localparam int TW = $clog2(TILT_MAX) + 1;  // signed tilt width
  localparam int RW = $clog2(EIGHTH + 1);    // octant angle width

  localparam int SENS_W = 16;
  localparam logic [SENS_W-1:0] SENS_RESET = 16'd410;

  // whole turns removed by a restoring pass over TURN << NRED .. TURN
  localparam int NRED = 11;
  localparam int KW   = $clog2(NRED + 1);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [HW-1:0]        heading;
    logic signed [TW-1:0] tilt;
    logic signed [31:0]   eye_x;
    logic signed [31:0]   eye_y;
    logic signed [31:0]   eye_z;
  } clav_job_t;

endpackage

// ===== src/clav_if.sv =====
// ----------------------------------------------------------------------------
// clav_if
// Valid/ready channels of the camera view block.
// ----------------------------------------------------------------------------
interface clav_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  modport source (output valid, delta_x, delta_y, eye_x, eye_y, eye_z, input ready);
  modport sink (input valid, delta_x, delta_y, eye_x, eye_y, eye_z, output ready);
endinterface

interface clav_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface clav_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] side_x;
  logic signed [15:0] side_y;
  logic signed [15:0] side_z;
  logic signed [15:0] upward_x;
  logic signed [15:0] upward_y;
  logic signed [15:0] upward_z;
  logic signed [15:0] back_x;
  logic signed [15:0] back_y;
  logic signed [15:0] back_z;
  logic signed [32:0] shift_x;
  logic signed [32:0] shift_y;
  logic signed [32:0] shift_z;
  modport source (output valid, side_x, side_y, side_z, upward_x, upward_y, upward_z,
                  back_x, back_y, back_z, shift_x, shift_y, shift_z, input ready);
  modport sink (input valid, side_x, side_y, side_z, upward_x, upward_y, upward_z,
                back_x, back_y, back_z, shift_x, shift_y, shift_z, output ready);
endinterface

// ===== src/clav_front.sv =====
// ----------------------------------------------------------------------------
// clav_front
// Takes mouse words, scales the deltas, wraps the heading, clamps the tilt
// and pushes the new angles with the eye position into the job queue.
// ----------------------------------------------------------------------------
module clav_front (
  input  logic                clk,
  input  logic                rst_n,
  clav_in_if.sink             in_ch,
  clav_cfg_if.sink            cfg_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output clav_pkg::clav_job_t push_job
);
  import clav_pkg::*;

  localparam int DW = 33 + SPD_SH;
  localparam int SW = DW;

  localparam logic [2:0] FS_IDLE = 3'd0;
  localparam logic [2:0] FS_MUL  = 3'd1;
  localparam logic [2:0] FS_ADD  = 3'd2;
  localparam logic [2:0] FS_RED  = 3'd3;
  localparam logic [2:0] FS_PUSH = 3'd4;

  logic [2:0]           fst_r, fst_nxt;
  logic [SENS_W-1:0]    sens_r;
  logic signed [15:0]   dx_r, dy_r;
  logic signed [31:0]   ex_r, ey_r, ez_r;
  logic signed [32:0]   px_r, py_r;
  logic [HW-1:0]        heading_r;
  logic signed [TW-1:0] tilt_r, tnew_r;
  logic [SW-1:0]        red_r;
  logic [KW-1:0]        k_r;

  logic signed [DW-1:0] psx, psy, dh, dt;
  logic signed [SW-1:0] hsum, tsum;
  logic [SW-1:0]        red_c;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (fst_r == FS_IDLE);
  assign push_valid   = (fst_r == FS_PUSH);

  assign push_job.heading = red_r[HW-1:0];
  assign push_job.tilt    = tnew_r;
  assign push_job.eye_x   = ex_r;
  assign push_job.eye_y   = ey_r;
  assign push_job.eye_z   = ez_r;

  // delta * sens * SPD / 4096, rounded half up to whole steps
  assign psx  = $signed({px_r, {SPD_SH{1'b0}}});
  assign psy  = $signed({py_r, {SPD_SH{1'b0}}});
  assign dh   = (psx + $signed(DW'(2048))) >>> 12;
  assign dt   = (psy + $signed(DW'(2048))) >>> 12;
  assign hsum = $signed({{(SW-HW){1'b0}}, heading_r}) + dh;
  assign tsum = {{(SW-TW){tilt_r[TW-1]}}, tilt_r} - dt;
  assign red_c = SW'(TURN) << k_r;

  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      FS_IDLE: if (in_ch.valid) fst_nxt = FS_MUL;
      FS_MUL:  fst_nxt = FS_ADD;
      FS_ADD:  fst_nxt = FS_RED;
      FS_RED:  if (k_r == '0) fst_nxt = FS_PUSH;
      FS_PUSH: if (push_ready) fst_nxt = FS_IDLE;
      default: fst_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r     <= FS_IDLE;
      sens_r    <= SENS_RESET;
      heading_r <= '0;
      tilt_r    <= '0;
    end else begin
      fst_r <= fst_nxt;
      if (cfg_ch.valid) sens_r <= cfg_ch.data;
      if (fst_r == FS_PUSH && push_ready) begin
        heading_r <= red_r[HW-1:0];
        tilt_r    <= tnew_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (fst_r)
      FS_IDLE: begin
        dx_r <= in_ch.delta_x;
        dy_r <= in_ch.delta_y;
        ex_r <= in_ch.eye_x;
        ey_r <= in_ch.eye_y;
        ez_r <= in_ch.eye_z;
      end
      FS_MUL: begin
        px_r <= dx_r * $signed({1'b0, sens_r});
        py_r <= dy_r * $signed({1'b0, sens_r});
      end
      FS_ADD: begin
        // shift a negative heading up by whole turns before the reduction
        red_r <= hsum[SW-1] ? SW'(hsum + $signed(SW'(TURN) << NRED)) : SW'(hsum);
        k_r   <= KW'(NRED);
        if (tsum > $signed(SW'(TILT_MAX)))       tnew_r <= TW'(TILT_MAX);
        else if (tsum < -$signed(SW'(TILT_MAX))) tnew_r <= -TW'(TILT_MAX);
        else                                     tnew_r <= tsum[TW-1:0];
      end
      FS_RED: begin
        if (red_r >= red_c) red_r <= red_r - red_c;
        if (k_r != '0) k_r <= k_r - 1'b1;
      end
      FS_PUSH: ;
      default: ;
    endcase
  end

endmodule

// ===== src/clav_queue.sv =====
// ----------------------------------------------------------------------------
// clav_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module clav_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  clav_pkg::clav_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output clav_pkg::clav_job_t pop_job
);
  import clav_pkg::*;

  clav_job_t      slot_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r < (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_job;
  end

endmodule

// ===== src/clav_back.sv =====
// ----------------------------------------------------------------------------
// clav_back
// Sine/cosine series, matrix products and translation dot products over one
// shared multiplier, sequenced step by step; result held in an output register.
// ----------------------------------------------------------------------------
module clav_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  clav_pkg::clav_job_t pop_job,
  clav_out_if.source          out_ch
);
  import clav_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PREP = 5'd1;
  localparam logic [4:0] ST_S0   = 5'd2;   // radians
  localparam logic [4:0] ST_S1   = 5'd3;   // x squared
  localparam logic [4:0] ST_S2   = 5'd4;
  localparam logic [4:0] ST_S3   = 5'd5;
  localparam logic [4:0] ST_S4   = 5'd6;
  localparam logic [4:0] ST_S5   = 5'd7;
  localparam logic [4:0] ST_S6   = 5'd8;
  localparam logic [4:0] ST_S7   = 5'd9;   // sine done
  localparam logic [4:0] ST_S8   = 5'd10;
  localparam logic [4:0] ST_S9   = 5'd11;
  localparam logic [4:0] ST_S10  = 5'd12;
  localparam logic [4:0] ST_S11  = 5'd13;
  localparam logic [4:0] ST_S12  = 5'd14;
  localparam logic [4:0] ST_S13  = 5'd15;
  localparam logic [4:0] ST_S14  = 5'd16;  // cosine done
  localparam logic [4:0] ST_E0   = 5'd17;
  localparam logic [4:0] ST_E1   = 5'd18;
  localparam logic [4:0] ST_E2   = 5'd19;
  localparam logic [4:0] ST_E3   = 5'd20;
  localparam logic [4:0] ST_D0   = 5'd21;
  localparam logic [4:0] ST_D1   = 5'd22;
  localparam logic [4:0] ST_D2   = 5'd23;
  localparam logic [4:0] ST_D3   = 5'd24;
  localparam logic [4:0] ST_D4   = 5'd25;
  localparam logic [4:0] ST_D5   = 5'd26;
  localparam logic [4:0] ST_D6   = 5'd27;
  localparam logic [4:0] ST_D7   = 5'd28;
  localparam logic [4:0] ST_OUT  = 5'd29;

  localparam logic [30:0] ONE    = 31'h4000_0000;
  localparam logic [32:0] RADQ30 = 33'd18740330;
  localparam logic [32:0] M42 = 33'((64'd1 << 32) / 64'd42);
  localparam logic [32:0] M20 = 33'((64'd1 << 32) / 64'd20);
  localparam logic [32:0] M6  = 33'((64'd1 << 32) / 64'd6);
  localparam logic [32:0] M56 = 33'((64'd1 << 32) / 64'd56);
  localparam logic [32:0] M30 = 33'((64'd1 << 32) / 64'd30);
  localparam logic [32:0] M12 = 33'((64'd1 << 32) / 64'd12);
  localparam logic [32:0] M2  = 33'((64'd1 << 32) / 64'd2);

  logic [4:0]           st_r, st_nxt;
  logic                 ph_r, ang_r;
  logic [HW-1:0]        hd_r;
  logic signed [TW-1:0] tl_r;
  logic signed [31:0]   ex_r, ey_r, ez_r;
  logic [1:0]           q_r;
  logic                 sw_r;
  logic [RW-1:0]        rr_r;
  logic [30:0]          x_r, x2_r, t_r, tmp_r, dvd_r;
  logic signed [15:0]   s14_r;
  logic signed [15:0]   sy_r, cy_r, sp_r, cp_r, upx_r, upz_r, bkx_r, bkz_r;
  logic signed [32:0]   shx_r, shy_r, shz_r;
  logic signed [49:0]   acc_r;
  logic signed [65:0]   prod_r;
  logic                 ov_r;

  logic signed [32:0] op_a, op_b;
  logic [5:0]         dv;
  logic               load_out;

  function automatic logic signed [32:0] e16(input logic signed [15:0] v);
    return {{17{v[15]}}, v};
  endfunction

  function automatic logic signed [32:0] u31(input logic [30:0] v);
    return $signed({2'b00, v});
  endfunction

  function automatic logic signed [32:0] e32(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // -(round half up of sum / 2^14), saturated to 33 bits
  function automatic logic signed [32:0] fin(input logic signed [49:0] s);
    logic signed [49:0] r;
    logic signed [49:0] n;
    r = (s + 50'sd8192) >>> 14;
    n = -r;
    if (n > 50'sd4294967295)       return 33'sh0_FFFF_FFFF;
    else if (n < -50'sd4294967296) return 33'sh1_0000_0000;
    else                           return n[32:0];
  endfunction

  // ---- angle reduction to quadrant and octant
  logic signed [HW+1:0] ma;
  logic [HW-1:0]        m;
  logic [1:0]           qc;
  logic [HW-1:0]        rq;

  always_comb begin
    ma = ang_r ? $signed({{(HW+2-TW){tl_r[TW-1]}}, tl_r}) : $signed({2'b00, hd_r});
    if (ma < 0) ma = ma + $signed((HW+2)'(TURN));
    m = ma[HW-1:0];
    if (m >= HW'(3 * QUARTER))      qc = 2'd3;
    else if (m >= HW'(2 * QUARTER)) qc = 2'd2;
    else if (m >= HW'(QUARTER))     qc = 2'd1;
    else                            qc = 2'd0;
    rq = m - HW'(QUARTER) * HW'(qc);
  end

  // ---- shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    dv   = 6'd1;
    unique case (st_r)
      ST_S0:  begin op_a = $signed({{(33-RW){1'b0}}, rr_r}); op_b = $signed(RADQ30); end
      ST_S1:  begin op_a = u31(x_r);   op_b = u31(x_r); end
      ST_S2:  begin op_a = u31(x2_r);  op_b = $signed(M42); dv = 6'd42; end
      ST_S3:  begin op_a = u31(x2_r);  op_b = u31(t_r); end
      ST_S4:  begin op_a = u31(tmp_r); op_b = $signed(M20); dv = 6'd20; end
      ST_S5:  begin op_a = u31(x2_r);  op_b = u31(t_r); end
      ST_S6:  begin op_a = u31(tmp_r); op_b = $signed(M6); dv = 6'd6; end
      ST_S7:  begin op_a = u31(x_r);   op_b = u31(t_r); end
      ST_S8:  begin op_a = u31(x2_r);  op_b = $signed(M56); dv = 6'd56; end
      ST_S9:  begin op_a = u31(x2_r);  op_b = u31(t_r); end
      ST_S10: begin op_a = u31(tmp_r); op_b = $signed(M30); dv = 6'd30; end
      ST_S11: begin op_a = u31(x2_r);  op_b = u31(t_r); end
      ST_S12: begin op_a = u31(tmp_r); op_b = $signed(M12); dv = 6'd12; end
      ST_S13: begin op_a = u31(x2_r);  op_b = u31(t_r); end
      ST_S14: begin op_a = u31(tmp_r); op_b = $signed(M2); dv = 6'd2; end
      ST_E0:  begin op_a = e16(cy_r);  op_b = e16(sp_r); end
      ST_E1:  begin op_a = e16(sy_r);  op_b = e16(sp_r); end
      ST_E2:  begin op_a = e16(cy_r);  op_b = e16(cp_r); end
      ST_E3:  begin op_a = e16(sy_r);  op_b = e16(cp_r); end
      ST_D0:  begin op_a = -e16(sy_r); op_b = e32(ex_r); end
      ST_D1:  begin op_a = e16(cy_r);  op_b = e32(ez_r); end
      ST_D2:  begin op_a = e16(upx_r); op_b = e32(ex_r); end
      ST_D3:  begin op_a = e16(cp_r);  op_b = e32(ey_r); end
      ST_D4:  begin op_a = e16(upz_r); op_b = e32(ez_r); end
      ST_D5:  begin op_a = e16(bkx_r); op_b = e32(ex_r); end
      ST_D6:  begin op_a = -e16(sp_r); op_b = e32(ey_r); end
      ST_D7:  begin op_a = e16(bkz_r); op_b = e32(ez_r); end
      default: ;
    endcase
  end

  // ---- post-processing of the registered product
  logic [65:0]        qm_full;
  logic [30:0]        qm;
  logic [30:0]        dq0, dq, tdiv;
  logic [36:0]        drem;
  logic signed [15:0] m14;
  logic signed [15:0] s14, c14, os, oc, ps, pc;
  logic signed [49:0] dsum;
  logic [30:0]        xq;

  always_comb begin
    qm_full = prod_r + 66'sd536870912;
    qm      = qm_full[60:30];
    dq0     = prod_r[62:32];
    drem    = {6'd0, dvd_r} - 37'({6'd0, dq0} * {31'd0, dv});
    dq      = dq0 + 31'(drem >= 37'(dv));
    tdiv    = ONE - dq;
    m14     = 16'(-((prod_r + 66'sd8192) >>> 14));
    xq      = 31'((prod_r + 66'(SPD / 2)) >> SPD_SH);
    s14     = 16'((32'(qm) + 32'd32768) >> 16);
    c14     = 16'((32'(tdiv) + 32'd32768) >> 16);
    dsum    = acc_r + prod_r[49:0];
    os      = sw_r ? c14 : s14_r;
    oc      = sw_r ? s14_r : c14;
    unique case (q_r)
      2'd0: begin ps = os;  pc = oc;  end
      2'd1: begin ps = oc;  pc = -os; end
      2'd2: begin ps = -os; pc = -oc; end
      2'd3: begin ps = -oc; pc = os;  end
      default: begin ps = os; pc = oc; end
    endcase
  end

  assign pop_ready = (st_r == ST_IDLE);
  assign load_out  = (st_r == ST_OUT) && (!ov_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    priority if (st_r == ST_IDLE) begin
      if (pop_valid) st_nxt = ST_PREP;
    end else if (st_r == ST_PREP) begin
      st_nxt = ST_S0;
    end else if (st_r == ST_OUT) begin
      if (load_out) st_nxt = ST_IDLE;
    end else if (ph_r) begin
      if (st_r == ST_S14)     st_nxt = ang_r ? ST_E0 : ST_PREP;
      else if (st_r == ST_D7) st_nxt = ST_OUT;
      else                    st_nxt = st_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ph_r  <= 1'b0;
      ang_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE || st_r == ST_PREP || st_r == ST_OUT) ph_r <= 1'b0;
      else                                                      ph_r <= ~ph_r;
      if (st_r == ST_IDLE)                 ang_r <= 1'b0;
      else if (st_r == ST_S14 && ph_r)     ang_r <= 1'b1;
      if (load_out)          ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      hd_r <= pop_job.heading;
      tl_r <= pop_job.tilt;
      ex_r <= pop_job.eye_x;
      ey_r <= pop_job.eye_y;
      ez_r <= pop_job.eye_z;
    end
    if (st_r == ST_PREP) begin
      q_r  <= qc;
      sw_r <= (rq > HW'(EIGHTH));
      rr_r <= (rq > HW'(EIGHTH)) ? RW'(HW'(QUARTER) - rq) : RW'(rq);
    end
    if (!ph_r) begin
      prod_r <= op_a * op_b;
      dvd_r  <= op_a[30:0];
    end else begin
      unique case (st_r)
        ST_S0:  x_r  <= xq;
        ST_S1:  x2_r <= qm;
        ST_S2, ST_S4, ST_S6, ST_S8, ST_S10, ST_S12: t_r <= tdiv;
        ST_S3, ST_S5, ST_S9, ST_S11, ST_S13: tmp_r <= qm;
        ST_S7:  s14_r <= s14;
        ST_S14: begin
          if (ang_r) begin
            sp_r <= ps;
            cp_r <= pc;
          end else begin
            sy_r <= ps;
            cy_r <= pc;
          end
        end
        ST_E0:  upx_r <= m14;
        ST_E1:  upz_r <= m14;
        ST_E2:  bkx_r <= m14;
        ST_E3:  bkz_r <= m14;
        ST_D0, ST_D2, ST_D5: acc_r <= prod_r[49:0];
        ST_D3, ST_D6: acc_r <= dsum;
        ST_D1:  shx_r <= fin(dsum);
        ST_D4:  shy_r <= fin(dsum);
        ST_D7:  shz_r <= fin(dsum);
        default: ;
      endcase
    end
    if (load_out) begin
      out_ch.side_x   <= -sy_r;
      out_ch.side_y   <= '0;
      out_ch.side_z   <= cy_r;
      out_ch.upward_x <= upx_r;
      out_ch.upward_y <= cp_r;
      out_ch.upward_z <= upz_r;
      out_ch.back_x   <= bkx_r;
      out_ch.back_y   <= -sp_r;
      out_ch.back_z   <= bkz_r;
      out_ch.shift_x  <= shx_r;
      out_ch.shift_y  <= shy_r;
      out_ch.shift_z  <= shz_r;
    end
  end

  assign out_ch.valid = ov_r;

endmodule

// ===== src/camera_look_at_view.sv =====
// ----------------------------------------------------------------------------
// camera_look_at_view
// Mouse-look camera: yaw/pitch update and right-handed look-at view matrix.
// ----------------------------------------------------------------------------
// Each input word passes through the front (delta scaling, a 12-step
// restoring pass that wraps the heading, tilt clamp) and then the back,
// where one shared 33x33 multiplier runs every series term, matrix product
// and dot-product term as a multiply step followed by a post-processing
// step. The back sets the sustained rate, as it takes a new job only when
// idle. A two-deep job queue lets the front take the next word while the
// back is busy, and the output register holds a finished result while the
// back starts on the next job. Configuration is always ready.
module camera_look_at_view (
  input  logic       clk,
  input  logic       rst_n,
  clav_in_if.sink    in_ch,
  clav_cfg_if.sink   cfg_ch,
  clav_out_if.source out_ch
);
  import clav_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  clav_job_t push_job, pop_job;

  clav_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  clav_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  clav_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

  a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_job.heading < HW'(TURN)))
    else $error("heading out of range");

  a_tilt_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_job.tilt <= $signed(TW'(TILT_MAX)) &&
                    push_job.tilt >= -$signed(TW'(TILT_MAX))))
    else $error("tilt beyond limit");

  a_side_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.side_y == 16'sd0))
    else $error("side_y not zero");

  a_up_y_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.upward_y >= 16'sd0))
    else $error("cos pitch negative");

endmodule
